// ----- rtl/fadr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fadr_pkg: shared constants for the fraction add/divide/reduce unit
// Holds operation codes, status codes and the fixed port widths.
// ----------------------------------------------------------------------------
package fadr_pkg;

  // Fixed widths of the operand and result ports.
  localparam int unsigned IN_W  = 32;
  localparam int unsigned RES_W = 64;

  // Operation codes carried by req_type.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DIV    = 2'd1;
  localparam logic [1:0] OP_REDUCE = 2'd2;

  // Status codes reported with each result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVF      = 2'd1;
  localparam logic [1:0] ST_ZERO_GCD = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/fraction_add_divide_reduce_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_add_divide_reduce_top: rational add, divide and gcd reduction
// A small sequencer drives one shared signed multiplier and one shift-subtract
// divide unit to add, divide or reduce fractions one transaction at a time.
// ----------------------------------------------------------------------------
// Add walks the three multiply states and divide the first two; an unknown operation code
// strobes a zero fraction straight from idle. Reduce is data dependent: each Euclid step
// runs one align/subtract division for its quotient bits, then the gcd state finds the zero
// remainder and the two final divisions by the gcd give the reduced numerator and denominator.
// busy is low in the cycle that strobes the result, so the next transaction can be taken
// then. The receiver cannot stall. Reset is asynchronous, active low, and returns to idle.
module fraction_add_divide_reduce_top #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [1:0]                   req_type_i,
  input  wire  [fadr_pkg::IN_W-1:0]    a_num_i,
  input  wire  [fadr_pkg::IN_W-1:0]    a_den_i,
  input  wire  [fadr_pkg::IN_W-1:0]    b_num_i,
  input  wire  [fadr_pkg::IN_W-1:0]    b_den_i,
  output logic                         done_o,
  output logic [fadr_pkg::RES_W-1:0]   res_num_o,
  output logic [fadr_pkg::RES_W-1:0]   res_den_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * OPERAND_WIDTH;
  localparam int unsigned RW = fadr_pkg::RES_W;

  // Sequencer states. The three multiply states serve add and divide; the gcd
  // state launches Euclid steps, and align/subtract form the divide unit.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_GCD,
    S_ALIGN,
    S_SUB
  } state_e;

  // What the divide unit is currently computing for the reduce sequence.
  typedef enum logic [1:0] {
    CTX_GCD,
    CTX_NUM,
    CTX_DEN
  } ctx_e;

  state_e             state_q;
  ctx_e               ctx_q;
  logic [1:0]         op_q;
  logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic [RW-1:0]      num_q, den_q;
  logic [1:0]         status_q;
  logic               done_q;

  // Euclid state: magnitudes of the current pair, the parity of the index of
  // the first element, and the sign of the final gcd.
  logic [W-1:0]       gm_q, gn_q;
  logic               par_q;
  logic               gs_q;

  // Divide unit registers: running remainder, shifted divisor, one-hot
  // quotient bit and the quotient built so far.
  logic [W-1:0]       rem_q, dvs_q, qbit_q, quo_q;

  // Shared multiplier.
  logic signed [W-1:0]  mul_x, mul_y;
  logic signed [PW-1:0] prod;
  logic [RW-1:0]        prod_ext;

  // Divide unit datapath.
  logic [W-1:0]       dvs_dbl;
  logic               can_align;
  logic               take;
  logic [W-1:0]       rem_next, quo_next;

  // Add path.
  logic [RW-1:0]      sum;
  logic               sum_ovf;

  // Reduce helpers.
  logic [W-1:0]       an_mag, ad_mag;
  logic [RW-1:0]      quo_ext;
  logic               quo_neg;
  logic [RW-1:0]      quo_signed;

  function automatic logic [OPERAND_WIDTH-1:0] mag(input logic [OPERAND_WIDTH-1:0] v);
    mag = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // The multiplier takes a_num*b_den, then b_num*a_den, then a_den*b_den.
  always_comb begin
    case (state_q)
      S_MUL_A: begin
        mul_x = an_q;
        mul_y = bd_q;
      end
      S_MUL_B: begin
        mul_x = bn_q;
        mul_y = ad_q;
      end
      default: begin
        mul_x = ad_q;
        mul_y = bd_q;
      end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign prod_ext = RW'(prod);

  // Both cross products sit in num_q and den_q when the sum is formed. The sum
  // can only leave the signed range when both operands share a sign.
  assign sum     = num_q + den_q;
  assign sum_ovf = (num_q[RW-1] == den_q[RW-1]) && (sum[RW-1] != num_q[RW-1]);

  // The divisor is doubled while it still fits under the remainder; then the
  // unit walks back down, subtracting where it can, one quotient bit a cycle.
  assign dvs_dbl   = {dvs_q[W-2:0], 1'b0};
  assign can_align = !dvs_q[W-1] && (dvs_dbl <= rem_q);
  assign take      = (rem_q >= dvs_q);
  assign rem_next  = take ? (rem_q - dvs_q) : rem_q;
  assign quo_next  = take ? (quo_q | qbit_q) : quo_q;

  assign an_mag = mag(an_q);
  assign ad_mag = mag(ad_q);

  // The quotient's sign is the dividend's sign against the gcd's sign.
  assign quo_ext    = RW'(quo_next);
  assign quo_neg    = (ctx_q == CTX_NUM) ? (an_q[W-1] ^ gs_q) : (ad_q[W-1] ^ gs_q);
  assign quo_signed = quo_neg ? (~quo_ext + 1'b1) : quo_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ctx_q    <= CTX_GCD;
      done_q   <= 1'b0;
      op_q     <= fadr_pkg::OP_ADD;
      an_q     <= '0;
      ad_q     <= '0;
      bn_q     <= '0;
      bd_q     <= '0;
      num_q    <= '0;
      den_q    <= '0;
      status_q <= fadr_pkg::ST_OK;
      gm_q     <= '0;
      gn_q     <= '0;
      par_q    <= 1'b0;
      gs_q     <= 1'b0;
      rem_q    <= '0;
      dvs_q    <= '0;
      qbit_q   <= '0;
      quo_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q     <= req_type_i;
            an_q     <= a_num_i[W-1:0];
            ad_q     <= a_den_i[W-1:0];
            bn_q     <= b_num_i[W-1:0];
            bd_q     <= b_den_i[W-1:0];
            status_q <= fadr_pkg::ST_OK;
            num_q    <= '0;
            den_q    <= '0;
            case (req_type_i)
              fadr_pkg::OP_ADD, fadr_pkg::OP_DIV: begin
                done_q  <= 1'b0;
                state_q <= S_MUL_A;
              end
              fadr_pkg::OP_REDUCE: begin
                gm_q    <= mag(a_num_i[W-1:0]);
                gn_q    <= mag(a_den_i[W-1:0]);
                par_q   <= 1'b0;
                done_q  <= 1'b0;
                state_q <= S_GCD;
              end
              default: begin
                // An unknown operation returns a zero fraction at once.
                done_q <= 1'b1;
              end
            endcase
          end else begin
            done_q <= 1'b0;
          end
        end

        S_MUL_A: begin
          num_q   <= prod_ext;
          done_q  <= 1'b0;
          state_q <= S_MUL_B;
        end

        S_MUL_B: begin
          den_q <= prod_ext;
          if (op_q == fadr_pkg::OP_ADD) begin
            done_q  <= 1'b0;
            state_q <= S_MUL_C;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end

        S_MUL_C: begin
          num_q    <= sum;
          den_q    <= prod_ext;
          status_q <= sum_ovf ? fadr_pkg::ST_OVF : fadr_pkg::ST_OK;
          state_q  <= S_IDLE;
          done_q   <= 1'b1;
        end

        S_GCD: begin
          if (gn_q == '0) begin
            if (gm_q == '0) begin
              status_q <= fadr_pkg::ST_ZERO_GCD;
              state_q  <= S_IDLE;
              done_q   <= 1'b1;
            end else begin
              // Signs alternate along the remainder chain, so the gcd takes
              // the sign of a_num or a_den by the parity of its position.
              gs_q    <= par_q ? ad_q[W-1] : an_q[W-1];
              rem_q   <= an_mag;
              dvs_q   <= gm_q;
              qbit_q  <= W'(1);
              quo_q   <= '0;
              ctx_q   <= CTX_NUM;
              done_q  <= 1'b0;
              state_q <= S_ALIGN;
            end
          end else begin
            rem_q   <= gm_q;
            dvs_q   <= gn_q;
            qbit_q  <= W'(1);
            quo_q   <= '0;
            ctx_q   <= CTX_GCD;
            done_q  <= 1'b0;
            state_q <= S_ALIGN;
          end
        end

        S_ALIGN: begin
          done_q <= 1'b0;
          if (can_align) begin
            dvs_q  <= dvs_dbl;
            qbit_q <= {qbit_q[W-2:0], 1'b0};
          end else begin
            state_q <= S_SUB;
          end
        end

        S_SUB: begin
          if (qbit_q[0]) begin
            case (ctx_q)
              CTX_GCD: begin
                gm_q    <= gn_q;
                gn_q    <= rem_next;
                par_q   <= ~par_q;
                done_q  <= 1'b0;
                state_q <= S_GCD;
              end
              CTX_NUM: begin
                num_q   <= quo_signed;
                rem_q   <= ad_mag;
                dvs_q   <= gm_q;
                qbit_q  <= W'(1);
                quo_q   <= '0;
                ctx_q   <= CTX_DEN;
                done_q  <= 1'b0;
                state_q <= S_ALIGN;
              end
              default: begin
                den_q   <= quo_signed;
                state_q <= S_IDLE;
                done_q  <= 1'b1;
              end
            endcase
          end else begin
            rem_q  <= rem_next;
            quo_q  <= quo_next;
            dvs_q  <= {1'b0, dvs_q[W-1:1]};
            qbit_q <= {1'b0, qbit_q[W-1:1]};
            done_q <= 1'b0;
          end
        end

        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign res_num_o = num_q;
  assign res_den_o = den_q;
  assign status_o  = status_q;

  // A result is only strobed once the sequencer is back at idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while the sequencer is still working");

  // A strobe follows either a working sequence or a transaction accepted
  // at idle.
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transaction");

  // Reducing 0/0 reports a zero fraction along with its error status.
  a_zero_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == fadr_pkg::ST_ZERO_GCD)) |-> ((res_num_o == '0) && (res_den_o == '0)))
    else $error("zero gcd result carries a nonzero fraction");

  // An accepted add keeps the block busy through its multiply sequence.
  a_add_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == fadr_pkg::OP_ADD)) |=> busy ##1 busy)
    else $error("add transaction finished too early");

endmodule

`default_nettype wire
